// ===== hdl/imu_complementary_attitude_macros.svh =====
// Assertion macros for the attitude estimator.
`ifndef IMU_COMPLEMENTARY_ATTITUDE_MACROS_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define IMU_CA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("imu_ca check failed");
// Condition must never be seen outside reset.
`define IMU_CA_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("imu_ca bad condition");
`else
`define IMU_CA_ASSERT(lbl, clk, rst, prop)
`define IMU_CA_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== hdl/imu_ca_pkg.sv =====
`default_nettype none
package imu_ca_pkg;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_RESET  = 1'b1;

  localparam logic REG_BLEND = 1'b0;
  localparam logic REG_GAIN  = 1'b1;

  localparam logic [15:0] BLEND_RESET = 16'd64225;
  localparam logic [31:0] GAIN_RESET  = 32'd572220;

  localparam logic [31:0] DT_LIMIT   = 32'd100000;
  localparam logic [16:0] DT_DEFAULT = 17'd5000;

  localparam logic signed [31:0] HALF_PI = 32'sd421657428;

  // rounding divide of the integration product by 16e6 = 2^10 * 15625:
  // q = (((n + 8e6) >> 10) * ceil(2^68 / 15625)) >> 68, exact for 54-bit operands
  localparam logic [63:0] DIV_ROUND = 64'd8000000;
  localparam logic [54:0] DIV_RECIP = 55'd18889465931478581;
  localparam logic [2:0]  DIV_LAST  = 3'd4;

  localparam logic signed [24:0] DEG_MUL = 25'sd15019745;

  // atan(2^-i) in 2^-28 rad
  function automatic logic signed [31:0] atan_tab(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd210828714;
      5'd1:  v = 32'sd124459457;
      5'd2:  v = 32'sd65760959;
      5'd3:  v = 32'sd33381290;
      5'd4:  v = 32'sd16755422;
      5'd5:  v = 32'sd8385879;
      5'd6:  v = 32'sd4193963;
      5'd7:  v = 32'sd2097109;
      5'd8:  v = 32'sd1048571;
      5'd9:  v = 32'sd524287;
      5'd29: v = 32'sd1;
      5'd30: v = 32'sd0;
      5'd31: v = 32'sd0;
      default: v = 32'sd1 <<< (5'd28 - idx);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/imu_ca_mul.sv =====
`default_nettype none
// Shared signed multiplier, product registered.
module imu_ca_mul import imu_ca_pkg::*; (
  input  wire logic               clk,
  input  wire logic signed [48:0] op_a,
  input  wire logic signed [24:0] op_b,
  output logic signed [73:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule
`default_nettype wire

// ===== hdl/imu_ca_div.sv =====
`default_nettype none
// Divide by 16e6 with round-half-up: reciprocal multiply, four 27x28 partial
// products summed in turn, done pulsed when the sum is complete.
module imu_ca_div import imu_ca_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] num,
  output logic             done,
  output logic [40:0]      quot
);

  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  rnd;
  logic [53:0]  m2;
  logic [26:0]  a_sel;
  logic [27:0]  b_sel;
  logic [6:0]   sh_sel;
  logic [54:0]  pp;
  logic [6:0]   pp_sh;
  logic [108:0] acc;

  assign rnd  = num + DIV_ROUND;
  assign quot = acc[108:68];

  // partial product select: low/high halves of m2 and of the reciprocal
  always_comb begin
    case (cnt)
      3'd0: begin
        a_sel  = m2[26:0];
        b_sel  = DIV_RECIP[27:0];
        sh_sel = 7'd0;
      end
      3'd1: begin
        a_sel  = m2[26:0];
        b_sel  = {1'b0, DIV_RECIP[54:28]};
        sh_sel = 7'd28;
      end
      3'd2: begin
        a_sel  = m2[53:27];
        b_sel  = DIV_RECIP[27:0];
        sh_sel = 7'd27;
      end
      default: begin
        a_sel  = m2[53:27];
        b_sel  = {1'b0, DIV_RECIP[54:28]};
        sh_sel = 7'd55;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        m2   <= rnd[63:10];
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        pp    <= 55'(a_sel) * 55'(b_sel);
        pp_sh <= sh_sel;
        // product registered in pp, then accumulated into acc
        if (cnt != 3'd0) begin
          acc <= acc + (109'(pp) << pp_sh);
        end
        cnt <= cnt + 3'd1;
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/imu_ca_isqrt.sv =====
`default_nettype none
// Integer square root, one result bit per cycle.
module imu_ca_isqrt import imu_ca_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] num,
  output logic             done,
  output logic [23:0]      root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [47:0] rem;
  logic [47:0] r;
  logic [5:0]  sh;
  logic [47:0] bitv;
  logic [47:0] t;

  assign sh   = 6'd46 - {cnt, 1'b0};
  assign bitv = 48'd1 << sh;
  assign t    = r + bitv;
  assign root = r[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        r    <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= t) begin
          rem <= rem - t;
          r   <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/imu_ca_cordic.sv =====
`default_nettype none
// CORDIC vectoring atan2, one micro-rotation per cycle.
module imu_ca_cordic import imu_ca_pkg::*; #(
  parameter int STEPS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] y_in,
  input  wire logic signed [31:0] x_in,
  output logic                    done,
  output logic signed [31:0]      angle
);

  localparam logic [4:0] LAST = 5'(STEPS - 1);

  logic               busy;
  logic [4:0]         cnt;
  logic signed [31:0] x, y, z;
  logic signed [31:0] xs, ys, a;

  assign xs    = x >>> cnt;
  assign ys    = y >>> cnt;
  assign a     = atan_tab(cnt);
  assign angle = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (x_in == 32'sd0 && y_in == 32'sd0) begin
          z    <= '0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          if (x_in < 0) begin
            // fold left half plane by a quarter turn
            if (y_in >= 0) begin
              x <= y_in;
              y <= -x_in;
              z <= HALF_PI;
            end else begin
              x <= -y_in;
              y <= x_in;
              z <= -HALF_PI;
            end
          end else begin
            x <= x_in;
            y <= y_in;
            z <= '0;
          end
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + a;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - a;
        end
        cnt <= cnt + 5'd1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/imu_complementary_attitude.sv =====
// Channel   Dir  Handshake               Payload
// in        in   in_valid / in_stall     action, accel_x/y/z, gyro_x/y/z, time_us
// out       out  out_valid / out_stall   pitch_deg, roll_deg, yaw_deg, stamp_us
// cfg       in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A sample request runs the square root, then the pitch and roll arctangents
// (a zero vector skips the micro-rotations), then per gyro axis two products and
// the reciprocal divide, then the blend and the degree scaling of each angle.
// A reset request is done in the cycle it is accepted and gives no result.
// in_stall is high while a sample is in work; the result register holds one
// result, so a new request is taken while it waits on out_stall.
// rst is synchronous: angles, time base and registers go to reset values.
`default_nettype none
`include "imu_complementary_attitude_macros.svh"
module imu_complementary_attitude import imu_ca_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               action,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic signed [15:0] gyro_x,
  input  wire logic signed [15:0] gyro_y,
  input  wire logic signed [15:0] gyro_z,
  input  wire logic [31:0]        time_us,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [25:0]      pitch_deg,
  output logic signed [25:0]      roll_deg,
  output logic signed [25:0]      yaw_deg,
  output logic [31:0]             stamp_us,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data
);

  typedef enum logic [18:0] {
    ST_IDLE = 19'h00001,
    ST_SQ_A = 19'h00002,  // ay^2
    ST_SQ_B = 19'h00004,  // az^2
    ST_SQ_C = 19'h00008,  // launch sqrt
    ST_ROOT = 19'h00010,  // wait sqrt, launch pitch atan2
    ST_ATP  = 19'h00020,  // wait pitch atan2, launch roll atan2
    ST_ATR  = 19'h00040,  // wait roll atan2
    ST_G_M1 = 19'h00080,  // |rate| * gain
    ST_G_M2 = 19'h00100,  // * dt
    ST_G_DV = 19'h00200,  // launch divide
    ST_G_WT = 19'h00400,  // wait divide, accumulate and saturate
    ST_B_P  = 19'h00800,  // pitch blend product
    ST_B_PW = 19'h01000,  // pitch blend sum, roll product
    ST_B_RW = 19'h02000,  // roll blend sum
    ST_D_P  = 19'h04000,  // degree scaling, one angle per cycle
    ST_D_R  = 19'h08000,
    ST_D_Y  = 19'h10000,
    ST_D_W  = 19'h20000,
    ST_OUT  = 19'h40000   // hand result to the output register
  } state_t;

  state_t state;

  // config registers
  logic [15:0] blend_weight;
  logic [31:0] gyro_gain;

  // filter state
  logic signed [39:0] pitch_angle, roll_angle, yaw_angle;
  logic [31:0]        last_stamp;

  // captured request
  logic signed [15:0] ax, ay, az, gx, gy, gz;
  logic [31:0]        stamp;
  logic [16:0]        delta;

  // working values
  logic [31:0]        sq_lo;
  logic signed [31:0] pacc, racc;
  logic [1:0]         axis;
  logic signed [39:0] gsum [3];
  logic signed [25:0] res_p, res_r, res_y;

  logic in_fire, cfg_fire, out_free;
  logic [31:0] dt_raw;

  // shared multiplier
  logic signed [48:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [73:0] prod;

  // sqrt, CORDIC and divider hookup
  logic               sq_start, sq_done;
  logic [47:0]        sq_num;
  logic [23:0]        root;
  logic               cor_start, cor_done;
  logic signed [31:0] cor_y, cor_x, cor_angle;
  logic               div_start, div_done;
  logic [40:0]        quot;

  // gyro integration
  logic signed [15:0] raw;
  logic               raw_neg;
  logic [15:0]        mag16;
  logic signed [39:0] ang_in;
  logic signed [42:0] sum43;
  logic signed [39:0] sat40;

  // blend
  logic signed [40:0] bdiff;
  logic signed [31:0] bacc;
  logic signed [57:0] bsum;

  // degree scaling
  logic signed [39:0] dsel, dprev;
  logic [39:0]        dmag;
  logic [63:0]        dround;
  logic [25:0]        dval;
  logic signed [25:0] dres;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;
  assign dt_raw    = time_us - last_stamp;

  imu_ca_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  imu_ca_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .num   (sq_num),
    .done  (sq_done),
    .root  (root)
  );

  imu_ca_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .done  (cor_done),
    .angle (cor_angle)
  );

  imu_ca_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod[63:0]),
    .done  (div_done),
    .quot  (quot)
  );

  // per-axis gyro select: pitch from gyro y, roll from gyro x, yaw from gyro z
  always_comb begin
    case (axis)
      2'd0: begin
        raw    = gy;
        ang_in = pitch_angle;
      end
      2'd1: begin
        raw    = gx;
        ang_in = roll_angle;
      end
      default: begin
        raw    = gz;
        ang_in = yaw_angle;
      end
    endcase
    raw_neg = raw[15];
    mag16   = raw_neg ? 16'(-raw) : raw;
    sum43   = raw_neg ? (43'(ang_in) - $signed({2'b00, quot}))
                      : (43'(ang_in) + $signed({2'b00, quot}));
    if (sum43[42:39] == 4'b0000 || sum43[42:39] == 4'b1111) begin
      sat40 = sum43[39:0];
    end else if (sum43[42]) begin
      sat40 = 40'sh80_0000_0000;
    end else begin
      sat40 = 40'sh7F_FFFF_FFFF;
    end
  end

  // blend: a*g + (1-a)*acc = acc + a*(g-acc)
  always_comb begin
    bacc  = (state == ST_B_RW) ? racc : pacc;
    bdiff = (state == ST_B_P) ? (41'(gsum[0]) - 41'(pacc))
                              : (41'(gsum[1]) - 41'(racc));
    bsum  = (58'(bacc) <<< 16) + $signed(prod[57:0]) + 58'sd32768;
  end

  // degrees: round(|ang| * DEG_MUL / 2^38), sign restored
  always_comb begin
    case (state)
      ST_D_P: begin
        dsel  = pitch_angle;
        dprev = pitch_angle;
      end
      ST_D_R: begin
        dsel  = roll_angle;
        dprev = pitch_angle;
      end
      ST_D_Y: begin
        dsel  = yaw_angle;
        dprev = roll_angle;
      end
      default: begin
        dsel  = yaw_angle;
        dprev = yaw_angle;
      end
    endcase
    dmag   = dsel[39] ? 40'(-dsel) : 40'(dsel);
    dround = prod[63:0] + 64'h20_0000_0000;
    dval   = dround[63:38];
    dres   = dprev[39] ? $signed(26'(-dval)) : $signed(dval);
  end

  // multiplier operands and unit launches
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    sq_start  = 1'b0;
    sq_num    = {sq_lo + prod[31:0], 16'h0000};
    cor_start = 1'b0;
    cor_y     = -(32'(ax) <<< 8);
    cor_x     = {8'h00, root};
    div_start = 1'b0;
    case (state)
      ST_SQ_A: begin
        mul_a = 49'(ay);
        mul_b = 25'(ay);
      end
      ST_SQ_B: begin
        mul_a = 49'(az);
        mul_b = 25'(az);
      end
      ST_SQ_C: sq_start = 1'b1;
      ST_ROOT: cor_start = sq_done;
      ST_ATP: begin
        cor_start = cor_done;
        cor_y     = 32'(ay) <<< 8;
        cor_x     = 32'(az) <<< 8;
      end
      ST_G_M1: begin
        mul_a = $signed({17'h0, gyro_gain});
        mul_b = $signed({9'h0, mag16});
      end
      ST_G_M2: begin
        mul_a = $signed({1'b0, prod[47:0]});
        mul_b = $signed({8'h00, delta});
      end
      ST_G_DV: div_start = 1'b1;
      ST_B_P, ST_B_PW: begin
        mul_a = 49'(bdiff);
        mul_b = $signed({9'h0, blend_weight});
      end
      ST_D_P, ST_D_R, ST_D_Y: begin
        mul_a = $signed({9'h0, dmag});
        mul_b = DEG_MUL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      blend_weight <= BLEND_RESET;
      gyro_gain    <= GAIN_RESET;
      pitch_angle  <= '0;
      roll_angle   <= '0;
      yaw_angle    <= '0;
      last_stamp   <= '0;
      out_valid    <= 1'b0;
      axis         <= '0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          REG_BLEND: blend_weight <= cfg_data[15:0];
          REG_GAIN:  gyro_gain    <= cfg_data;
          default: ;
        endcase
      end
      // ST_OUT reloads the register itself when it is freed
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            last_stamp <= time_us;
            if (action == ACT_RESET) begin
              pitch_angle <= '0;
              roll_angle  <= '0;
              yaw_angle   <= '0;
            end else begin
              ax    <= accel_x;
              ay    <= accel_y;
              az    <= accel_z;
              gx    <= gyro_x;
              gy    <= gyro_y;
              gz    <= gyro_z;
              stamp <= time_us;
              // out-of-range step falls back to a nominal 5 ms
              if (dt_raw == 32'd0 || dt_raw >= DT_LIMIT) begin
                delta <= DT_DEFAULT;
              end else begin
                delta <= dt_raw[16:0];
              end
              state <= ST_SQ_A;
            end
          end
        end
        ST_SQ_A: state <= ST_SQ_B;
        ST_SQ_B: begin
          sq_lo <= prod[31:0];
          state <= ST_SQ_C;
        end
        ST_SQ_C: state <= ST_ROOT;
        ST_ROOT: begin
          if (sq_done) begin
            state <= ST_ATP;
          end
        end
        ST_ATP: begin
          if (cor_done) begin
            pacc  <= cor_angle;
            state <= ST_ATR;
          end
        end
        ST_ATR: begin
          if (cor_done) begin
            racc  <= cor_angle;
            axis  <= 2'd0;
            state <= ST_G_M1;
          end
        end
        ST_G_M1: state <= ST_G_M2;
        ST_G_M2: state <= ST_G_DV;
        ST_G_DV: state <= ST_G_WT;
        ST_G_WT: begin
          if (div_done) begin
            gsum[axis] <= sat40;
            if (axis == 2'd2) begin
              state <= ST_B_P;
            end else begin
              axis  <= axis + 2'd1;
              state <= ST_G_M1;
            end
          end
        end
        ST_B_P: state <= ST_B_PW;
        ST_B_PW: begin
          pitch_angle <= bsum[55:16];
          state       <= ST_B_RW;
        end
        ST_B_RW: begin
          roll_angle <= bsum[55:16];
          yaw_angle  <= gsum[2];
          state      <= ST_D_P;
        end
        ST_D_P: state <= ST_D_R;
        ST_D_R: begin
          res_p <= dres;
          state <= ST_D_Y;
        end
        ST_D_Y: begin
          res_r <= dres;
          state <= ST_D_W;
        end
        ST_D_W: begin
          res_y <= dres;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            pitch_deg <= res_p;
            roll_deg  <= res_r;
            yaw_deg   <= res_y;
            stamp_us  <= stamp;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `IMU_CA_ASSERT(a_out_from_seq, clk, rst, $rose(out_valid) |-> $past(state == ST_OUT))
  `IMU_CA_ASSERT(a_reset_no_work, clk, rst, (in_fire && action == ACT_RESET) |=> (state == ST_IDLE))
  `IMU_CA_ASSERT(a_delta_range, clk, rst, (state == ST_SQ_A) |-> (delta != 17'd0 && delta < DT_LIMIT))
  `IMU_CA_NEVER(a_div_done_stray, clk, rst, div_done && (state != ST_G_WT))

endmodule
`default_nettype wire

// ===== tb/tb_imu_complementary_attitude.sv =====
`timescale 1ns / 100ps
`default_nettype none

// Testbench for the complementary-filter attitude estimator.
// Requests go in on the in channel, one result per sample request comes back on
// the out channel, and a reset request only resets the angles and the time base.
// A behavioral model in this file tracks angles, time base and both registers.
// On every accepted sample request it queues the expected angles. A checker pops
// them in order against every accepted result.
module tb_imu_complementary_attitude;
  import imu_ca_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 400;   // extra wait after the queue empties

  typedef struct packed {
    logic signed [25:0] pitch;
    logic signed [25:0] roll;
    logic signed [25:0] yaw;
    logic [31:0]        stamp;
  } attitude_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_SAMPLE;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic [31:0] time_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [25:0] pitch_deg, roll_deg, yaw_deg;
  logic [31:0] stamp_us;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_BLEND;
  logic [31:0] cfg_data = '0;

  imu_complementary_attitude dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z), .time_us(time_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .pitch_deg(pitch_deg), .roll_deg(roll_deg), .yaw_deg(yaw_deg),
    .stamp_us(stamp_us),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Attitude model: own copy of registers and filter state
  // ---------------------------------------------------------------------------
  logic [15:0] mdl_alpha;
  logic [31:0] mdl_gain;
  longint      mdl_pitch, mdl_roll, mdl_yaw;   // radians in 2^-28
  logic [31:0] mdl_last_stamp;
  longint      arctan_q28 [32];                // atan(2^-i), 2^-28 rad

  attitude_t attitude_q[$];                    // expected results, oldest first

  int idle_pct_send = 0;
  int idle_pct_recv = 0;
  int hold_token = 0;
  int mismatches = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int resets_sent = 0;
  logic [31:0] send_clock = '0;               // timestamp of the last request sent

  // arctangent of 2^-i from the odd power series, rounded to 2^-28
  function automatic longint arctan_pow2(int i);
    longint acc;
    longint term;
    int e;
    acc = 0;
    if (i == 0) return 64'sd210828714;
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > 62) break;
      term = longint'((64'd1 << (62 - e)) / (2 * k + 1));
      acc = (k % 2) ? acc - term : acc + term;
    end
    return (acc + (64'sd1 <<< 33)) >>> 34;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring arctangent; left half plane is pre-rotated by a quarter turn
  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint t;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI;
      end else begin
        x = -y; y = t; z = -HALF_PI;
      end
    end
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + arctan_q28[i];
      end else begin
        x = x - ys; y = y + xs; z = z - arctan_q28[i];
      end
    end
    return z;
  endfunction

  // rate * gain * dt, rounded; the product fits the 64-bit variable
  function automatic longint gyro_step(longint ang, longint rate, logic [31:0] dt);
    logic [63:0] n;
    longint inc;
    longint s;
    n = (rate < 0) ? -rate : rate;
    n = n * mdl_gain;
    n = n * dt;
    inc = longint'((n + 64'd8000000) / 64'd16000000);
    s = (rate < 0) ? ang - inc : ang + inc;
    if (s > (64'sd1 <<< 39) - 1) s = (64'sd1 <<< 39) - 1;
    if (s < -(64'sd1 <<< 39)) s = -(64'sd1 <<< 39);
    return s;
  endfunction

  function automatic longint mix(longint gyro_ang, longint acc_ang);
    longint a;
    a = longint'(mdl_alpha);
    return (a * gyro_ang + (65536 - a) * acc_ang + 32768) >>> 16;
  endfunction

  function automatic logic [25:0] rad_to_deg256(longint ang);
    logic [63:0] mag;
    logic [63:0] d;
    mag = (ang < 0) ? -ang : ang;
    d = (mag * 64'd15019745 + (64'd1 << 37)) >> 38;
    if (ang < 0) d = -d;
    return d[25:0];
  endfunction

  // advance the model by one accepted request, queue the result it yields
  task automatic predict_attitude(logic act, logic signed [15:0] ax, ay, az,
                                  logic signed [15:0] gx, gy, gz, logic [31:0] t);
    logic [31:0] dt;
    longint p_acc;
    longint r_acc;
    longint p_gyro;
    longint r_gyro;
    attitude_t res;
    if (act == ACT_RESET) begin
      mdl_pitch = 0; mdl_roll = 0; mdl_yaw = 0;
      mdl_last_stamp = t;
      return;
    end
    dt = t - mdl_last_stamp;
    if (dt == 0 || dt >= DT_LIMIT) dt = 32'd5000;
    mdl_last_stamp = t;
    p_acc = vector_angle(-longint'(ax) * 256,
        longint'(int_sqrt((64'(longint'(ay) * ay) + 64'(longint'(az) * az)) << 16)));
    r_acc = vector_angle(longint'(ay) * 256, longint'(az) * 256);
    p_gyro = gyro_step(mdl_pitch, gy, dt);
    r_gyro = gyro_step(mdl_roll, gx, dt);
    mdl_yaw = gyro_step(mdl_yaw, gz, dt);
    mdl_pitch = mix(p_gyro, p_acc);
    mdl_roll = mix(r_gyro, r_acc);
    res.pitch = rad_to_deg256(mdl_pitch);
    res.roll = rad_to_deg256(mdl_roll);
    res.yaw = rad_to_deg256(mdl_yaw);
    res.stamp = t;
    attitude_q.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    attitude_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (attitude_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: stamp %0d", stamp_us);
      end else begin
        want = attitude_q.pop_front();
        if (want.pitch !== pitch_deg || want.roll !== roll_deg ||
            want.yaw !== yaw_deg || want.stamp !== stamp_us) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch stamp %0d: exp p/r/y %0d %0d %0d t %0d, got %0d %0d %0d t %0d",
                     want.stamp, want.pitch, want.roll, want.yaw, want.stamp,
                     pitch_deg, roll_deg, yaw_deg, stamp_us);
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct_recv);
    end
  end

  // Watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, attitude_q.size());
      $display("tb_imu_complementary_attitude NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Send one request; predict at acceptance, then maybe leave a gap.
  task automatic send_request(logic act, logic signed [15:0] ax, ay, az,
                              logic signed [15:0] gx, gy, gz, logic [31:0] t);
    in_valid <= 1'b1;
    action <= act;
    accel_x <= ax; accel_y <= ay; accel_z <= az;
    gyro_x <= gx; gyro_y <= gy; gyro_z <= gz;
    time_us <= t;
    do @(posedge clk); while (in_stall);
    predict_attitude(act, ax, ay, az, gx, gy, gz, t);
    send_clock = t;
    if (act == ACT_RESET) resets_sent++;
    else samples_sent++;
    if ($urandom_range(99) < idle_pct_send) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Drain results, then give a trailing reset request time to settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (attitude_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BLEND) mdl_alpha = val[15:0];
    else mdl_gain = val;
  endtask

  function automatic logic signed [15:0] rand_reading();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 4000)) - 2000);
      2: return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($signed($urandom_range(0, 33000)) - 16500);
    endcase
  endfunction

  // mostly in-range deltas, some zero, some too long, some wild jumps
  function automatic logic [31:0] next_stamp();
    case ($urandom_range(19))
      0: return send_clock;
      1: return send_clock + $urandom_range(100000, 2000000);
      2: return $urandom;
      3: return send_clock + 32'd99999;
      default: return send_clock + $urandom_range(1, 20000);
    endcase
  endfunction

  task automatic random_request();
    logic act;
    act = ($urandom_range(99) < 4) ? ACT_RESET : ACT_SAMPLE;
    send_request(act, rand_reading(), rand_reading(), rand_reading(),
                 rand_reading(), rand_reading(), rand_reading(), next_stamp());
  endtask

  task automatic test_extremes();
    send_request(ACT_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd1000);
    send_request(ACT_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000,
                 16'sh8000, 16'sh8000, 16'sh8000, 32'd2000);
    send_request(ACT_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sh8000,
                 16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF);
    // timestamp wraps through zero with a short delta
    send_request(ACT_SAMPLE, 16'sd100, -16'sd200, 16'sd16384,
                 16'sd5, -16'sd5, 16'sd0, 32'd500);
  endtask

  task automatic test_special_cases();
    // zero vector on both arctangents
    send_request(ACT_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd10500);
    // same timestamp twice: zero delta
    send_request(ACT_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd1000, 16'sd1000, 16'sd1000,
                 32'd10500);
    // delta at and just under the limit
    send_request(ACT_SAMPLE, 16'sd1, 16'sd1, 16'sd1, 16'sd30000, 16'sd30000, 16'sd30000,
                 32'd110500);
    send_request(ACT_SAMPLE, 16'sd1, 16'sd1, 16'sd1, -16'sd30000, 16'sd30000, 16'sd30000,
                 32'd210499);
    // roll vector in the left half plane, both signs of y, and on the axis
    send_request(ACT_SAMPLE, 16'sd0, 16'sd5000, -16'sd16000, 16'sd0, 16'sd0, 16'sd0,
                 32'd211000);
    send_request(ACT_SAMPLE, 16'sd0, -16'sd5000, -16'sd16000, 16'sd0, 16'sd0, 16'sd0,
                 32'd212000);
    send_request(ACT_SAMPLE, 16'sd3000, 16'sd0, -16'sd16000, 16'sd0, 16'sd0, 16'sd0,
                 32'd213000);
    // reset request: no result, restarts time base
    send_request(ACT_RESET, 16'sh7FFF, 16'sh8000, 16'sd1, 16'sd1, 16'sd1, 16'sd1,
                 32'd900000);
    send_request(ACT_SAMPLE, 16'sd0, 16'sd0, 16'sd16384, 16'sd100, 16'sd100, 16'sd100,
                 32'd901000);
    send_request(ACT_RESET, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd5);
    send_request(ACT_RESET, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd6);
    send_request(ACT_SAMPLE, -16'sd8000, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                 32'd6);
  endtask

  // saturation: big gain, big rate, long delta, drives the gyro integration toward its rails
  task automatic test_saturation();
    for (int i = 0; i < 6; i++)
      send_request(ACT_SAMPLE, 16'sd0, 16'sd0, 16'sd16384,
                   16'sh7FFF, 16'sh7FFF, 16'sh8000, send_clock + 32'd99999);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) random_request();
  endtask

  // long receiver hold-off while requests keep coming, block must stall input
  task automatic test_backpressure();
    hold_token++;
    for (int i = 0; i < 10; i++) random_request();
  endtask

  task automatic test_register_sweep();
    write_reg(REG_BLEND, 32'd0);          // accelerometer only
    write_reg(REG_GAIN, 32'hFFFF_FFFF);   // largest gain
    test_random(20);
    test_saturation();
    write_reg(REG_BLEND, 32'd65535);      // nearly gyro only
    write_reg(REG_GAIN, 32'd0);
    test_random(20);
    write_reg(REG_BLEND, 32'hDEAD_8000);  // upper bits dropped
    write_reg(REG_GAIN, 32'd85_000_000);
    test_saturation();
    test_random(20);
    write_reg(REG_BLEND, 32'(BLEND_RESET));
    write_reg(REG_GAIN, GAIN_RESET);
  endtask

  initial begin
    for (int i = 0; i < 32; i++) arctan_q28[i] = arctan_pow2(i);
    mdl_alpha = BLEND_RESET;
    mdl_gain = GAIN_RESET;
    mdl_pitch = 0; mdl_roll = 0; mdl_yaw = 0;
    mdl_last_stamp = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults from reset, no idling
    test_extremes();
    test_special_cases();
    test_register_sweep();

    // sender gaps 30%, receiver stalls 59%
    idle_pct_send = 30; idle_pct_recv = 59;
    test_random(380);
    test_backpressure();
    write_reg(REG_BLEND, 32'd40000);
    write_reg(REG_GAIN, 32'($urandom));

    // roles swapped
    idle_pct_send = 59; idle_pct_recv = 30;
    test_random(380);
    test_backpressure();
    write_reg(REG_GAIN, 32'($urandom_range(0, 4000000)));
    write_reg(REG_BLEND, 32'($urandom));

    // full rate on both sides
    idle_pct_send = 0; idle_pct_recv = 0;
    test_random(380);

    wait_idle();
    $display("covered %0d sample and %0d reset requests, %0d results checked",
             samples_sent, resets_sent, results_seen);
    $display("register sweep, delta limits, left half plane, saturation, long hold-off");
    if (mismatches == 0 && attitude_q.size() == 0) begin
      $display("tb_imu_complementary_attitude OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_imu_complementary_attitude NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
